/* rtl/core/bmc_pkg.sv */
// shared types, codes and arithmetic helpers for the ball motion and collision block
`default_nettype none
package bmc_pkg;

  localparam int unsigned VAL_W      = 24;
  localparam int unsigned MASS_W     = 16;
  localparam int unsigned EXT_W      = 34;
  localparam int unsigned NUM_W      = 42;
  localparam int unsigned DEN_W      = 17;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;

  localparam logic [1:0] KIND_WRITE   = 2'd0;
  localparam logic [1:0] KIND_ADVANCE = 2'd1;
  localparam logic [1:0] KIND_RESOLVE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ARENA_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ARENA_HEIGHT = 2'd1;

  localparam logic [CFG_DATA_W-1:0] ARENA_WIDTH_RST  = 12'd800;
  localparam logic [CFG_DATA_W-1:0] ARENA_HEIGHT_RST = 12'd600;

  localparam int unsigned DEF_BALL_COUNT     = 16;
  localparam int unsigned DEF_MAX_SEP_STEPS  = 256;
  localparam int unsigned DEF_FRACTION_BITS  = 8;

  typedef struct packed {
    logic        [MASS_W-1:0] radius;
    logic        [MASS_W-1:0] mass;
    logic signed [VAL_W-1:0]  px;
    logic signed [VAL_W-1:0]  py;
    logic signed [VAL_W-1:0]  vx;
    logic signed [VAL_W-1:0]  vy;
    logic signed [VAL_W-1:0]  ax;
    logic signed [VAL_W-1:0]  ay;
  } ball_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] p;
    logic signed [VAL_W-1:0] v;
    logic signed [VAL_W-1:0] a;
  } axis_t;

  typedef enum logic [3:0] {
    S_IDLE, S_WR, S_ADV, S_RDA, S_RDB, S_NUM, S_DST, S_DWT,
    S_OVD, S_OVM, S_OVC, S_STA, S_STB, S_WBA, S_WBB
  } state_e;

  function automatic logic signed [VAL_W-1:0] sat24(input logic signed [EXT_W-1:0] x);
    logic signed [EXT_W-1:0] hi;
    logic signed [EXT_W-1:0] lo;
    hi = EXT_W'(8388607);
    lo = -EXT_W'(8388608);
    if (x > hi) return VAL_W'(hi);
    else if (x < lo) return VAL_W'(lo);
    else return VAL_W'(x);
  endfunction

  // bounce, integrate, clamp on one axis
  function automatic axis_t move_axis(input axis_t s, input logic [MASS_W-1:0] rad,
                                      input logic signed [EXT_W-1:0] wall);
    logic signed [EXT_W-1:0] p;
    logic signed [EXT_W-1:0] v;
    logic signed [EXT_W-1:0] a;
    logic signed [EXT_W-1:0] r;
    axis_t o;
    p = EXT_W'(s.p);
    v = EXT_W'(s.v);
    a = EXT_W'(s.a);
    r = $signed(EXT_W'(rad));
    if (!((r < p) && (p + r < wall))) begin
      v = EXT_W'(sat24(-v));
      a = EXT_W'(sat24(-a));
    end
    v = EXT_W'(sat24(v + a));
    p = EXT_W'(sat24(p + v));
    if (p < r) p = r;
    if (p > wall - r) p = wall - r;
    o.p = sat24(p);
    o.v = VAL_W'(v);
    o.a = VAL_W'(a);
    return o;
  endfunction

  function automatic ball_t ball_advance(input ball_t b, input logic signed [EXT_W-1:0] wx,
                                         input logic signed [EXT_W-1:0] wy);
    axis_t xs;
    axis_t ys;
    ball_t o;
    xs = move_axis('{p: b.px, v: b.vx, a: b.ax}, b.radius, wx);
    ys = move_axis('{p: b.py, v: b.vy, a: b.ay}, b.radius, wy);
    o = b;
    o.px = xs.p;
    o.vx = xs.v;
    o.ax = xs.a;
    o.py = ys.p;
    o.vy = ys.v;
    o.ay = ys.a;
    return o;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/ball_motion_and_collision_top.sv */
// top level: ball table, advance and pairwise elastic collision sequencer
// channels: input words (valid/ready), result words (valid/ready), config writes (always ready)
// the ball table is one synchronous memory, read in the cycle after the address is issued
// write: stored when accepted, then its result is issued; advance: read, then update and write back
// resolve: 2 reads, then four 42-step serial divisions (skipped when the two masses sum
//   to zero), then an overlap test (difference, square, compare) and separation rounds
//   (advance the first ball, then the second), up to MAX_SEPARATION_STEPS rounds, then two results
// one item is processed at a time; the next item is taken once the previous has
//   issued all of its results into the output register
// the output register holds a result until taken; a stall on the result side
//   holds the sequencer in its result state
// reset returns the sequencer to idle and the arena to 800 by 600; the table is not
//   cleared and must be written before it is read
// kind 3 is taken and dropped with no result
`default_nettype none
module ball_motion_and_collision_top import bmc_pkg::*; #(
  parameter int unsigned BALL_COUNT           = DEF_BALL_COUNT,
  parameter int unsigned MAX_SEPARATION_STEPS = DEF_MAX_SEP_STEPS,
  parameter int unsigned FRACTION_BITS        = DEF_FRACTION_BITS
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [1:0]             kind_i,
  input  wire logic [3:0]             first_index_i,
  input  wire logic [3:0]             second_index_i,
  input  wire logic [15:0]            new_radius_i,
  input  wire logic [15:0]            new_mass_i,
  input  wire logic signed [23:0]     new_pos_x_i,
  input  wire logic signed [23:0]     new_pos_y_i,
  input  wire logic signed [23:0]     new_vel_x_i,
  input  wire logic signed [23:0]     new_vel_y_i,
  input  wire logic signed [23:0]     new_acc_x_i,
  input  wire logic signed [23:0]     new_acc_y_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [3:0]                  ball_index_o,
  output logic signed [23:0]          pos_x_o,
  output logic signed [23:0]          pos_y_o,
  output logic signed [23:0]          vel_x_o,
  output logic signed [23:0]          vel_y_o,
  output logic signed [23:0]          acc_x_o,
  output logic signed [23:0]          acc_y_o,
  output logic                        still_overlapping_o,
  output logic                        last_o,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned IW = $clog2(BALL_COUNT);
  localparam int unsigned SW = $clog2(MAX_SEPARATION_STEPS + 1);

  ball_t mem [BALL_COUNT];
  ball_t rd_q;

  state_e state_q, state_d;
  logic   out_valid_q;
  logic [CFG_DATA_W-1:0] arena_w_q, arena_h_q;
  logic [1:0]   k_q;
  logic [SW-1:0] steps_q;
  logic         flag_q;
  logic [IW-1:0] ia_q, ib_q;
  ball_t        a_q, b_q;
  logic signed [VAL_W-1:0] nv_q [3];
  logic signed [NUM_W-1:0] num_q;
  logic signed [VAL_W:0]   dx_q, dy_q;
  logic [DEN_W-1:0]        rs_q;
  logic [2*VAL_W+1:0]      dx2_q, dy2_q;
  logic [2*DEN_W-1:0]      rs2_q;

  logic [3:0]  ob_idx_q;
  ball_t       ob_q;
  logic        ob_flag_q, ob_last_q;

  logic        accept, out_free, emit, same, overlap, msum_nz;
  logic [IW-1:0] slot_a, slot_b;
  logic        mem_re, mem_we;
  logic [IW-1:0] rd_addr, wr_addr;
  ball_t       wr_data, in_ball, adv_src, adv_res, em_ball;
  logic [IW-1:0] em_slot;
  logic signed [EXT_W-1:0] wall_x, wall_y;
  logic        div_start, div_done;
  logic signed [VAL_W-1:0] div_q;
  logic signed [VAL_W-1:0] va, vb;
  logic [MASS_W-1:0]       ma, mb;
  logic [31:0] ta, tb;

  always_comb begin
    ta = 32'(first_index_i);
    tb = 32'(second_index_i);
    for (int i = 0; i < 8; i++) begin
      if (ta >= BALL_COUNT) ta = ta - BALL_COUNT;
      if (tb >= BALL_COUNT) tb = tb - BALL_COUNT;
    end
    slot_a = ta[IW-1:0];
    slot_b = tb[IW-1:0];
  end

  assign in_ball = '{radius: new_radius_i, mass: new_mass_i, px: new_pos_x_i,
                     py: new_pos_y_i, vx: new_vel_x_i, vy: new_vel_y_i,
                     ax: new_acc_x_i, ay: new_acc_y_i};

  assign wall_x   = $signed(EXT_W'(arena_w_q) << FRACTION_BITS);
  assign wall_y   = $signed(EXT_W'(arena_h_q) << FRACTION_BITS);
  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign same        = (ia_q == ib_q);
  assign overlap     = ({1'b0, dx2_q} + {1'b0, dy2_q}) <= (2*VAL_W+3)'(rs2_q);
  assign msum_nz     = ({1'b0, a_q.mass} + {1'b0, rd_q.mass}) != '0;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    unique case (state_q)
      S_ADV:   adv_src = rd_q;
      S_STA:   adv_src = a_q;
      default: adv_src = same ? a_q : b_q;
    endcase
    adv_res = ball_advance(adv_src, wall_x, wall_y);
  end

  // operands of the velocity exchange, second ball's pass swaps the roles
  always_comb begin
    ma = k_q[1] ? b_q.mass : a_q.mass;
    mb = k_q[1] ? a_q.mass : b_q.mass;
    if (!k_q[0]) begin
      va = k_q[1] ? b_q.vx : a_q.vx;
      vb = k_q[1] ? a_q.vx : b_q.vx;
    end else begin
      va = k_q[1] ? b_q.vy : a_q.vy;
      vb = k_q[1] ? a_q.vy : b_q.vy;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (kind_i)
            KIND_WRITE:   state_d = S_WR;
            KIND_ADVANCE: state_d = S_ADV;
            KIND_RESOLVE: state_d = S_RDA;
            default:      state_d = S_IDLE;
          endcase
        end
      end
      S_WR, S_ADV: if (out_free) state_d = S_IDLE;
      S_RDA: state_d = S_RDB;
      S_RDB: state_d = msum_nz ? S_NUM : S_OVD;
      S_NUM: state_d = S_DST;
      S_DST: state_d = S_DWT;
      S_DWT: begin
        if (div_done) state_d = (k_q == 2'd3) ? S_OVD : S_NUM;
      end
      S_OVD: state_d = S_OVM;
      S_OVM: state_d = S_OVC;
      S_OVC: begin
        if (overlap && (32'(steps_q) < MAX_SEPARATION_STEPS)) state_d = S_STA;
        else state_d = S_WBA;
      end
      S_STA: state_d = S_STB;
      S_STB: state_d = S_OVD;
      S_WBA: if (out_free) state_d = S_WBB;
      S_WBB: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // strobes and memory port selection
  always_comb begin
    emit      = 1'b0;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    rd_addr   = ib_q;
    wr_addr   = ia_q;
    wr_data   = a_q;
    em_ball   = a_q;
    em_slot   = ia_q;
    div_start = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        rd_addr = slot_a;
        mem_re  = accept;
        wr_addr = slot_a;
        wr_data = in_ball;
        mem_we  = accept && (kind_i == KIND_WRITE);
      end
      S_RDA: mem_re = 1'b1;
      S_WR:  emit = out_free;
      S_ADV: begin
        emit    = out_free;
        em_ball = adv_res;
        wr_data = adv_res;
        mem_we  = out_free;
      end
      S_DST: div_start = 1'b1;
      S_WBA: begin
        emit   = out_free;
        mem_we = out_free;
      end
      S_WBB: begin
        emit    = out_free;
        em_ball = b_q;
        em_slot = ib_q;
        wr_addr = ib_q;
        wr_data = b_q;
        mem_we  = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    if (mem_re) rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      arena_w_q   <= ARENA_WIDTH_RST;
      arena_h_q   <= ARENA_HEIGHT_RST;
      k_q         <= '0;
      steps_q     <= '0;
    end else begin
      state_q <= state_d;
      if (emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (cfg_valid_i) begin
        if (cfg_index_i == REG_ARENA_WIDTH) arena_w_q <= cfg_data_i;
        else if (cfg_index_i == REG_ARENA_HEIGHT) arena_h_q <= cfg_data_i;
      end
      if (accept) begin
        k_q     <= '0;
        steps_q <= '0;
      end else if (state_q == S_DWT && div_done) begin
        k_q <= k_q + 2'd1;
      end else if (state_q == S_STB) begin
        steps_q <= steps_q + SW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: if (accept) begin
        ia_q   <= slot_a;
        ib_q   <= slot_b;
        a_q    <= in_ball;
        flag_q <= 1'b0;
      end
      S_RDA: a_q <= rd_q;
      S_RDB: b_q <= rd_q;
      S_NUM: num_q <= NUM_W'(va) * NUM_W'($signed({1'b0, ma}) - $signed({1'b0, mb}))
                    + NUM_W'($signed({1'b0, mb, 1'b0})) * NUM_W'(vb);
      S_DWT: if (div_done) begin
        if (k_q == 2'd3) begin
          a_q.vx <= nv_q[0];
          a_q.vy <= nv_q[1];
          b_q.vx <= nv_q[2];
          b_q.vy <= div_q;
        end else begin
          nv_q[k_q] <= div_q;
        end
      end
      S_OVD: begin
        dx_q <= (VAL_W+1)'(a_q.px) - (VAL_W+1)'(b_q.px);
        dy_q <= (VAL_W+1)'(a_q.py) - (VAL_W+1)'(b_q.py);
        rs_q <= {1'b0, a_q.radius} + {1'b0, b_q.radius};
      end
      S_OVM: begin
        dx2_q <= (2*VAL_W+2)'((2*VAL_W+2)'(dx_q) * (2*VAL_W+2)'(dx_q));
        dy2_q <= (2*VAL_W+2)'((2*VAL_W+2)'(dy_q) * (2*VAL_W+2)'(dy_q));
        rs2_q <= (2*DEN_W)'(rs_q) * (2*DEN_W)'(rs_q);
      end
      S_OVC: if (overlap && (32'(steps_q) >= MAX_SEPARATION_STEPS)) flag_q <= 1'b1;
      S_STA: a_q <= adv_res;
      S_STB: begin
        b_q <= adv_res;
        if (same) a_q <= adv_res;
      end
      default: ;
    endcase
    if (emit) begin
      ob_idx_q  <= 4'(em_slot);
      ob_q      <= em_ball;
      ob_flag_q <= (state_q == S_WBA || state_q == S_WBB) ? flag_q : 1'b0;
      ob_last_q <= (state_q != S_WBA);
    end
  end

  bmc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   ({1'b0, a_q.mass} + {1'b0, b_q.mass}),
    .done_o  (div_done),
    .quot_o  (div_q)
  );

  assign out_valid_o         = out_valid_q;
  assign ball_index_o        = ob_idx_q;
  assign pos_x_o             = ob_q.px;
  assign pos_y_o             = ob_q.py;
  assign vel_x_o             = ob_q.vx;
  assign vel_y_o             = ob_q.vy;
  assign acc_x_o             = ob_q.ax;
  assign acc_y_o             = ob_q.ay;
  assign still_overlapping_o = ob_flag_q;
  assign last_o              = ob_last_q;

endmodule
`default_nettype wire

/* rtl/core/bmc_div.sv */
// bit-serial signed divider with 24-bit saturated quotient
`default_nettype none
module bmc_div import bmc_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic signed [NUM_W-1:0] num_i,
  input  wire logic        [DEN_W-1:0] den_i,
  output logic                         done_o,
  output logic signed [VAL_W-1:0]      quot_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             neg_q, neg_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W:0]   trial;
  logic [NUM_W-1:0] mag;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    trial  = {rem_q, quo_q[NUM_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      neg_d  = num_i[NUM_W-1];
      den_d  = den_i;
      rem_d  = '0;
      quo_d  = num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = DEN_W'(trial - {1'b0, den_q});
        quo_d = {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = DEN_W'(trial);
        quo_d = {quo_q[NUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(NUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  always_comb begin
    mag = quo_q;
    if (neg_q) begin
      if (mag >= NUM_W'(8388608)) quot_o = $signed(24'h800000);
      else quot_o = VAL_W'(-$signed(mag));
    end else begin
      if (mag > NUM_W'(8388607)) quot_o = $signed(24'h7fffff);
      else quot_o = VAL_W'(mag);
    end
  end

  assign done_o = done_q;

endmodule
`default_nettype wire

/* test/ball_motion_and_collision_top_tb.sv */
// self-checking testbench for the ball motion and collision block: directed table, then random items
`default_nettype none
module ball_motion_and_collision_top_tb import bmc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 16;
  localparam int SEP_BOUND = 256;
  localparam int FRAC = 8;
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int HOLD_CYCLES = 3000;
  localparam int ITEMS_PER_PHASE = 233;
  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct {
    logic [1:0]  kind;
    logic [3:0]  fi;
    logic [3:0]  si;
    logic [15:0] rad;
    logic [15:0] mass;
    logic [23:0] px, py, vx, vy, ax, ay;
  } item_t;

  typedef struct {
    logic [3:0]  idx;
    logic [23:0] px, py, vx, vy, ax, ay;
    logic        ovl;
    logic        lst;
  } result_t;

  typedef struct {
    item_t it;
    bit    typed;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  item_t drv = '{kind: KIND_WRITE, fi: 0, si: 0, rad: 0, mass: 0,
                 px: 0, py: 0, vx: 0, vy: 0, ax: 0, ay: 0};

  logic in_ready, out_valid, cfg_ready;
  logic [3:0] ball_index;
  logic signed [23:0] pos_x, pos_y, vel_x, vel_y, acc_x, acc_y;
  logic still_overlapping, last;

  ball_motion_and_collision_top dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .kind_i(drv.kind), .first_index_i(drv.fi), .second_index_i(drv.si),
    .new_radius_i(drv.rad), .new_mass_i(drv.mass),
    .new_pos_x_i(drv.px), .new_pos_y_i(drv.py),
    .new_vel_x_i(drv.vx), .new_vel_y_i(drv.vy),
    .new_acc_x_i(drv.ax), .new_acc_y_i(drv.ay),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .ball_index_o(ball_index), .pos_x_o(pos_x), .pos_y_o(pos_y),
    .vel_x_o(vel_x), .vel_y_o(vel_y), .acc_x_o(acc_x), .acc_y_o(acc_y),
    .still_overlapping_o(still_overlapping), .last_o(last),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow of the ball table and arena
  longint t_rad [SLOTS];
  longint t_mass[SLOTS];
  longint t_px[SLOTS], t_py[SLOTS], t_vx[SLOTS], t_vy[SLOTS], t_ax[SLOTS], t_ay[SLOTS];
  bit     written[SLOTS];
  longint arena_w = 800;
  longint arena_h = 600;

  result_t pending_results[$];
  int errors = 0;
  int send_gap = 0;
  int recv_stall = 0;
  bit hold_go = 0;
  bit holding = 0;
  int idle_cycles = 0;

  function automatic longint clip24(longint x);
    if (x > 64'sd8388607) return 64'sd8388607;
    if (x < -64'sd8388608) return -64'sd8388608;
    return x;
  endfunction

  function automatic void move_axis_pred(ref longint p, ref longint v, ref longint a,
                                         input longint r, input longint wall);
    if (!(r < p && p + r < wall)) begin
      v = clip24(-v);
      a = clip24(-a);
    end
    v = clip24(v + a);
    p = clip24(p + v);
    if (p < r) p = r;
    if (p > wall - r) p = wall - r;
    p = clip24(p);
  endfunction

  function automatic void step_ball(int i);
    move_axis_pred(t_px[i], t_vx[i], t_ax[i], t_rad[i], arena_w << FRAC);
    move_axis_pred(t_py[i], t_vy[i], t_ay[i], t_rad[i], arena_h << FRAC);
  endfunction

  function automatic bit touching(int i, int j);
    longint dx, dy, rs;
    dx = t_px[i] - t_px[j];
    dy = t_py[i] - t_py[j];
    rs = t_rad[i] + t_rad[j];
    return dx * dx + dy * dy <= rs * rs;
  endfunction

  function automatic longint bounce_vel(longint va, longint vb, longint ma, longint mb);
    return clip24((va * (ma - mb) + 2 * mb * vb) / (ma + mb));
  endfunction

  function automatic result_t snap(int i, bit ovl, bit lst);
    result_t r;
    r.idx = 4'(i);
    r.px = 24'(t_px[i]); r.py = 24'(t_py[i]);
    r.vx = 24'(t_vx[i]); r.vy = 24'(t_vy[i]);
    r.ax = 24'(t_ax[i]); r.ay = 24'(t_ay[i]);
    r.ovl = ovl;
    r.lst = lst;
    return r;
  endfunction

  function automatic void predict_item(item_t it, bit typed);
    int a, b, steps;
    longint ma, mb, vax, vay, vbx, vby;
    bit flag;
    result_t r;
    a = int'(it.fi) % SLOTS;
    b = int'(it.si) % SLOTS;
    flag = 0;
    steps = 0;
    case (it.kind)
      KIND_WRITE: begin
        t_rad[a] = it.rad; t_mass[a] = it.mass;
        t_px[a] = longint'($signed(it.px)); t_py[a] = longint'($signed(it.py));
        t_vx[a] = longint'($signed(it.vx)); t_vy[a] = longint'($signed(it.vy));
        t_ax[a] = longint'($signed(it.ax)); t_ay[a] = longint'($signed(it.ay));
        written[a] = 1;
        r = snap(a, 0, 1);
        // a write reads back exactly what was stored
        if (typed) begin
          r.idx = it.fi; r.px = it.px; r.py = it.py; r.vx = it.vx;
          r.vy = it.vy; r.ax = it.ax; r.ay = it.ay;
        end
        pending_results.push_back(r);
      end
      KIND_ADVANCE: begin
        step_ball(a);
        pending_results.push_back(snap(a, 0, 1));
      end
      KIND_RESOLVE: begin
        ma = t_mass[a];
        mb = t_mass[b];
        if (ma + mb != 0) begin
          vax = t_vx[a]; vay = t_vy[a]; vbx = t_vx[b]; vby = t_vy[b];
          t_vx[a] = bounce_vel(vax, vbx, ma, mb);
          t_vy[a] = bounce_vel(vay, vby, ma, mb);
          t_vx[b] = bounce_vel(vbx, vax, mb, ma);
          t_vy[b] = bounce_vel(vby, vay, mb, ma);
        end
        while (touching(a, b)) begin
          if (steps >= SEP_BOUND) begin
            flag = 1;
            break;
          end
          step_ball(a);
          step_ball(b);
          steps++;
        end
        pending_results.push_back(snap(a, flag, 0));
        pending_results.push_back(snap(b, flag, 1));
      end
      default: ;
    endcase
  endfunction

  function automatic item_t mk(logic [1:0] kind, logic [3:0] fi, logic [3:0] si,
                               logic [15:0] rad, logic [15:0] mass,
                               logic [23:0] px, logic [23:0] py, logic [23:0] vx,
                               logic [23:0] vy, logic [23:0] ax, logic [23:0] ay);
    item_t it;
    it.kind = kind; it.fi = fi; it.si = si; it.rad = rad; it.mass = mass;
    it.px = px; it.py = py; it.vx = vx; it.vy = vy; it.ax = ax; it.ay = ay;
    return it;
  endfunction

  function automatic logic [23:0] rnd24();
    return 24'($urandom);
  endfunction

  function automatic logic [23:0] srange(int lim);
    return 24'($signed($urandom_range(2 * lim)) - lim);
  endfunction

  // word offered at the falling edge, prediction made at the accepting edge
  task automatic send_word(item_t it, bit typed);
    @(negedge clk);
    if ($urandom_range(99) < send_gap) begin
      in_valid = 1'b0;
      while ($urandom_range(99) < send_gap) @(negedge clk);
    end
    drv = it;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_item(it, typed);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_ARENA_WIDTH) arena_w = data;
    else if (idx == REG_ARENA_HEIGHT) arena_h = data;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic item_t rand_write(int slot);
    item_t it;
    it = mk(KIND_WRITE, 4'(slot), 4'($urandom), 16'($urandom_range(256, 6000)),
            16'($urandom), 24'($urandom_range(0, int'(arena_w) * 256)),
            24'($urandom_range(0, int'(arena_h) * 256)), srange(3000), srange(3000),
            srange(80), srange(80));
    if ($urandom_range(99) < 15) begin
      it.rad = 16'($urandom); it.px = rnd24(); it.py = rnd24();
      it.vx = rnd24(); it.vy = rnd24(); it.ax = rnd24(); it.ay = rnd24();
    end
    if ($urandom_range(99) < 5) it.mass = '0;
    return it;
  endfunction

  function automatic int pick_written();
    int s;
    do s = $urandom_range(SLOTS - 1); while (!written[s]);
    return s;
  endfunction

  task automatic random_phase(int count);
    item_t it, partner;
    int a, b, sel;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(99);
      if (sel < 25) begin
        send_word(rand_write($urandom_range(SLOTS - 1)), 0);
      end else if (sel < 55) begin
        it = rand_write(0);
        it.kind = KIND_ADVANCE;
        it.fi = 4'(pick_written());
        send_word(it, 0);
      end else if (sel < 75) begin
        it = rand_write(0);
        it.kind = KIND_RESOLVE;
        it.fi = 4'(pick_written());
        it.si = 4'(pick_written());
        send_word(it, 0);
      end else if (sel < 95) begin
        // collision sequence: two balls close together, then resolve
        a = $urandom_range(SLOTS - 1);
        do b = $urandom_range(SLOTS - 1); while (b == a);
        it = rand_write(a);
        partner = rand_write(b);
        partner.px = 24'($signed(it.px) + $signed(srange(1500)));
        partner.py = 24'($signed(it.py) + $signed(srange(1500)));
        send_word(it, 0);
        send_word(partner, 0);
        it = rand_write(0);
        it.kind = KIND_RESOLVE;
        it.fi = 4'(a);
        it.si = 4'(b);
        send_word(it, 0);
      end else begin
        it = rand_write(0);
        it.kind = KIND_NONE;
        send_word(it, 0);
      end
    end
  endtask

  always @(negedge clk) out_ready <= !holding && ($urandom_range(99) >= recv_stall);

  always begin
    @(posedge hold_go);
    holding = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    holding = 1'b0;
  end

  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected, ball_index %0d", ball_index);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (ball_index !== e.idx) begin
          $error("ball_index expected %h got %h", e.idx, ball_index); errors++;
        end
        if (pos_x !== e.px) begin
          $error("pos_x expected %h got %h", e.px, pos_x); errors++;
        end
        if (pos_y !== e.py) begin
          $error("pos_y expected %h got %h", e.py, pos_y); errors++;
        end
        if (vel_x !== e.vx) begin
          $error("vel_x expected %h got %h", e.vx, vel_x); errors++;
        end
        if (vel_y !== e.vy) begin
          $error("vel_y expected %h got %h", e.vy, vel_y); errors++;
        end
        if (acc_x !== e.ax) begin
          $error("acc_x expected %h got %h", e.ax, acc_x); errors++;
        end
        if (acc_y !== e.ay) begin
          $error("acc_y expected %h got %h", e.ay, acc_y); errors++;
        end
        if (still_overlapping !== e.ovl) begin
          $error("still_overlapping expected %b got %b", e.ovl, still_overlapping); errors++;
        end
        if (last !== e.lst) begin
          $error("last expected %b got %b", e.lst, last); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    row_t table_rows[$];
    row_t row;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    table_rows.push_back('{mk(KIND_WRITE, 0, 0, 16'h0A00, 16'h0000, 24'(200 * 256),
        24'(200 * 256), 24'h7FFFFF, 24'h800000, 24'h000001, 24'hFFFFFF), 1});
    table_rows.push_back('{mk(KIND_WRITE, 1, 9, 16'h0A00, 16'h0000, 24'(205 * 256),
        24'(200 * 256), 24'hFFFF00, 24'h000100, 24'h0, 24'h0), 1});
    table_rows.push_back('{mk(KIND_RESOLVE, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0), 0});
    table_rows.push_back('{mk(KIND_ADVANCE, 0, 15, 16'hFFFF, 16'hFFFF, 24'h7FFFFF,
        24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000), 0});
    table_rows.push_back('{mk(KIND_WRITE, 15, 15, 16'hFFFF, 16'hFFFF, 24'h7FFFFF,
        24'h800000, 24'h0, 24'h0, 24'h7FFFFF, 24'h800000), 1});
    table_rows.push_back('{mk(KIND_ADVANCE, 15, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0});
    table_rows.push_back('{mk(KIND_RESOLVE, 15, 15, 0, 0, 0, 0, 0, 0, 0, 0), 0});
    table_rows.push_back('{mk(KIND_WRITE, 2, 0, 16'h0000, 16'h0001, 24'h0, 24'h0,
        24'h0, 24'h0, 24'h0, 24'h0), 1});
    table_rows.push_back('{mk(KIND_WRITE, 3, 0, 16'h0800, 16'h0300, 24'(400 * 256),
        24'(300 * 256), 24'd512, 24'hFFFED4, 24'h0, 24'd10), 1});
    table_rows.push_back('{mk(KIND_WRITE, 4, 0, 16'h0800, 16'h0100, 24'(410 * 256),
        24'(305 * 256), 24'hFFFE00, 24'd100, 24'h0, 24'h0), 1});
    table_rows.push_back('{mk(KIND_RESOLVE, 3, 4, 0, 0, 0, 0, 0, 0, 0, 0), 0});
    table_rows.push_back('{mk(KIND_ADVANCE, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0});
    table_rows.push_back('{mk(KIND_NONE, 5, 6, 16'hFFFF, 16'hFFFF, 24'hFFFFFF,
        24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF), 0});
    table_rows.push_back('{mk(KIND_RESOLVE, 2, 3, 0, 0, 0, 0, 0, 0, 0, 0), 0});
    table_rows.push_back('{mk(KIND_ADVANCE, 4, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0});
    table_rows.push_back('{mk(KIND_WRITE, 5, 0, 16'h0400, 16'hFFFF, 24'(799 * 256),
        24'(1 * 256), 24'h7FFFFF, 24'h0, 24'h800000, 24'h0), 1});
    table_rows.push_back('{mk(KIND_RESOLVE, 5, 3, 0, 0, 0, 0, 0, 0, 0, 0), 0});
    table_rows.push_back('{mk(KIND_ADVANCE, 3, 15, 0, 0, 0, 0, 0, 0, 0, 0), 0});
    table_rows.push_back('{mk(KIND_ADVANCE, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0});

    foreach (table_rows[i]) begin
      row = table_rows[i];
      send_word(row.it, row.typed);
    end
    drain();

    cfg_write(REG_SPARE, 12'hABC);
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin cfg_write(REG_ARENA_WIDTH, 12'hFFF); cfg_write(REG_ARENA_HEIGHT, 12'hFFF); end
        1: begin cfg_write(REG_ARENA_WIDTH, 12'd1); cfg_write(REG_ARENA_HEIGHT, 12'd1); end
        2: begin
          cfg_write(REG_ARENA_WIDTH, 12'($urandom_range(1, 4095)));
          cfg_write(REG_ARENA_HEIGHT, 12'($urandom_range(1, 4095)));
        end
        3: begin cfg_write(REG_ARENA_WIDTH, 12'd320); cfg_write(REG_ARENA_HEIGHT, 12'd240); end
        default: begin
          cfg_write(REG_ARENA_WIDTH, 12'd800); cfg_write(REG_ARENA_HEIGHT, 12'd600);
        end
      endcase
      send_gap = (ph == 1 || ph == 4) ? 64 : ((ph == 3) ? 14 : 0);
      recv_stall = (ph == 2) ? 64 : ((ph == 3) ? 14 : 0);
      if (ph == 4) begin
        send_gap = 0;
        hold_go = 1'b1;
      end
      random_phase(ITEMS_PER_PHASE);
      drain();
    end

    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire
